/* rtl/trc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank refill controller package
// Shared types, field widths and codes for the tank refill controller.
// ----------------------------------------------------------------------------
package trc_pkg;

	// Default width of the stage tick counter.
	localparam int COUNT_WIDTH_DEF = 16;

	// Field widths.
	localparam int TICK_W      = 16;
	localparam int LIMIT_W     = 16;
	localparam int THR_W       = 8;
	localparam int FAULT_W     = 8;
	localparam int EVENT_W     = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int S_TDATA_W   = 8;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 24;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0] STAGE_ONE_LIMIT_RST = 16'd600;
	localparam logic [LIMIT_W-1:0] STAGE_TWO_LIMIT_RST = 16'd600;
	localparam logic [THR_W-1:0]   SENSOR_THR_RST      = 8'd3;

	// Command carried with each input item.
	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_ENABLE  = 2'd1,
		ACT_DISABLE = 2'd2
	} action_t;

	// Refill stage.
	typedef enum logic [1:0] {
		STG_IDLE         = 2'd0,
		STG_EMPTY_TO_LOW = 2'd1,
		STG_LOW_TO_FULL  = 2'd2
	} stage_t;

	// Event reported with each result.
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE        = 4'd0,
		EV_START       = 4'd1,
		EV_STAGE1_DONE = 4'd2,
		EV_FULL        = 4'd3,
		EV_T1_TIMEOUT  = 4'd4,
		EV_T2_TIMEOUT  = 4'd5,
		EV_SKIP        = 4'd6,
		EV_SENSOR_ERR  = 4'd7,
		EV_REJECT      = 4'd8
	} event_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STAGE_ONE_LIMIT = 2'd0,
		CFG_STAGE_TWO_LIMIT = 2'd1,
		CFG_SENSOR_THR      = 2'd2
	} cfg_index_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [LIMIT_W-1:0] stage_one_limit;
		logic [LIMIT_W-1:0] stage_two_limit;
		logic [THR_W-1:0]   sensor_error_threshold;
	} cfg_regs_t;

	// Controller state apart from the tick counter.
	typedef struct packed {
		logic               enabled;
		stage_t             stage;
		logic [FAULT_W-1:0] fault_count;
		logic               drive;
	} ctl_state_t;

	// One input item.
	typedef struct packed {
		action_t action;
		logic    full_sensor;
		logic    low_sensor;
	} item_t;

endpackage

/* rtl/trc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank refill controller configuration registers
// Holds the stage timeouts and the sensor error threshold written by software.
// ----------------------------------------------------------------------------
module trc_cfg_regs import trc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_regs_t              cfg_q
);

	// A write to an index beyond the register list is taken and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stage_one_limit        <= STAGE_ONE_LIMIT_RST;
			cfg_q.stage_two_limit        <= STAGE_TWO_LIMIT_RST;
			cfg_q.sensor_error_threshold <= SENSOR_THR_RST;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_STAGE_ONE_LIMIT: begin
					cfg_q.stage_one_limit <= cfg_data;
				end
				CFG_STAGE_TWO_LIMIT: begin
					cfg_q.stage_two_limit <= cfg_data;
				end
				CFG_SENSOR_THR: begin
					cfg_q.sensor_error_threshold <= cfg_data[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/trc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank refill controller step logic
// Computes the next controller state and the event for one input item.
// ----------------------------------------------------------------------------
module trc_step import trc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  item_t                  item,
	input  cfg_regs_t              cfg,
	input  ctl_state_t             cur,
	input  logic [COUNT_WIDTH-1:0] cur_ticks,
	output ctl_state_t             nxt,
	output logic [COUNT_WIDTH-1:0] nxt_ticks,
	output event_t                 ev
);

	localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	logic [COUNT_WIDTH-1:0] ticks_bump;
	logic [FAULT_W-1:0]     fault_inc;
	logic                   both_on;
	logic                   lim1_hit;
	logic                   lim2_hit;

	// Saturating increments and the timeout compares.
	always_comb begin
		ticks_bump = (cur_ticks == {COUNT_WIDTH{1'b1}}) ? cur_ticks
		                                                : cur_ticks + COUNT_WIDTH'(1);
		fault_inc  = (cur.fault_count == {FAULT_W{1'b1}}) ? cur.fault_count
		                                                  : cur.fault_count + FAULT_W'(1);
		both_on    = item.full_sensor & item.low_sensor;
		lim1_hit   = CMP_W'(ticks_bump) >= CMP_W'(cfg.stage_one_limit);
		lim2_hit   = CMP_W'(ticks_bump) >= CMP_W'(cfg.stage_two_limit);
	end

	// Next state and event.
	always_comb begin
		nxt       = cur;
		nxt_ticks = cur_ticks;
		ev        = EV_NONE;
		case (item.action)
			ACT_TICK: begin
				if (cur.enabled) begin
					if (both_on) begin
						// Contradictory sensors: skip until the count passes the threshold.
						nxt.fault_count = fault_inc;
						if (fault_inc <= cfg.sensor_error_threshold) begin
							ev = EV_SKIP;
						end else begin
							nxt.enabled     = 1'b0;
							nxt.stage       = STG_IDLE;
							nxt.drive       = 1'b0;
							nxt.fault_count = '0;
							nxt_ticks       = '0;
							ev              = EV_SENSOR_ERR;
						end
					end else begin
						nxt.fault_count = '0;
						case (cur.stage)
							STG_EMPTY_TO_LOW: begin
								nxt_ticks = ticks_bump;
								if (item.full_sensor) begin
									nxt.stage = STG_IDLE;
									nxt.drive = 1'b0;
									nxt_ticks = '0;
									ev        = EV_FULL;
								end else if (!item.low_sensor) begin
									nxt.stage = STG_LOW_TO_FULL;
									nxt_ticks = '0;
									ev        = EV_STAGE1_DONE;
								end else if (lim1_hit) begin
									nxt.stage   = STG_IDLE;
									nxt.drive   = 1'b0;
									nxt.enabled = 1'b0;
									nxt_ticks   = '0;
									ev          = EV_T1_TIMEOUT;
								end
							end
							STG_LOW_TO_FULL: begin
								nxt_ticks = ticks_bump;
								if (item.full_sensor) begin
									nxt.stage = STG_IDLE;
									nxt.drive = 1'b0;
									nxt_ticks = '0;
									ev        = EV_FULL;
								end else if (item.low_sensor) begin
									nxt.stage = STG_EMPTY_TO_LOW;
									nxt.drive = 1'b1;
									nxt_ticks = '0;
									ev        = EV_START;
								end else if (lim2_hit) begin
									nxt.stage = STG_IDLE;
									nxt.drive = 1'b0;
									nxt_ticks = '0;
									ev        = EV_T2_TIMEOUT;
								end
							end
							default: begin
								// Idle, and the unused stage code treated as idle.
								nxt.stage = STG_IDLE;
								if (item.low_sensor) begin
									nxt.stage = STG_EMPTY_TO_LOW;
									nxt.drive = 1'b1;
									nxt_ticks = '0;
									ev        = EV_START;
								end
							end
						endcase
					end
				end
			end
			ACT_ENABLE: begin
				nxt.fault_count = '0;
				if (!cur.enabled) begin
					if (both_on) begin
						ev = EV_REJECT;
					end else begin
						nxt.enabled = 1'b1;
						nxt.stage   = STG_IDLE;
						nxt.drive   = 1'b0;
						nxt_ticks   = '0;
					end
				end
			end
			ACT_DISABLE: begin
				nxt.fault_count = '0;
				nxt.enabled     = 1'b0;
				nxt.stage       = STG_IDLE;
				nxt.drive       = 1'b0;
				nxt_ticks       = '0;
			end
			default: begin
				// Unused action code leaves everything as it is.
			end
		endcase
	end

endmodule

/* rtl/tank_refill_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank refill controller
// Tick-driven two-stage automatic refill sequencer for a tank with two float
// sensors, with stage timeouts and sensor fault handling.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  tuser: action; tdata: sensors
//  m_*       out        m_tvalid / m_tready  tdata: one result per item
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item is accepted per cycle when the output is not stalled; each item
//  gives one result, which passes through the input register and then the
//  result register before it is offered. The whole state update is one pass
//  of the step logic.
//  Reset clears the state and loads the register defaults; no clearing pass.
//  A stalled output holds its transaction and the input register holds the
//  next item, so the input side stalls only when both are full.
// ----------------------------------------------------------------------------
module tank_refill_controller_unit import trc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input items.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,  // [0] full_sensor, [1] low_sensor
	input  logic [S_TUSER_W-1:0]   s_tuser,  // [1:0] action
	// Results.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,  // [0] drive_on, [2:1] stage,
	                                         // [3] auto_enabled, [7:4] event_res,
	                                         // [23:8] tick_count
	// Configuration writes.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_regs_t              cfg_q;
	item_t                  item_s1;
	logic                   valid_s1;
	logic                   advance;
	ctl_state_t             state_q;
	ctl_state_t             state_nxt;
	logic [COUNT_WIDTH-1:0] ticks_q;
	logic [COUNT_WIDTH-1:0] ticks_nxt;
	event_t                 ev;
	logic                   out_valid_q;
	logic [M_TDATA_W-1:0]   out_data_q;

	assign cfg_ready = 1'b1;

	trc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_q     (cfg_q)
	);

	// The item moves on whenever the result register is free or being emptied.
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action      <= action_t'(s_tuser);
			item_s1.full_sensor <= s_tdata[0];
			item_s1.low_sensor  <= s_tdata[1];
		end
	end

	trc_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.item      (item_s1),
		.cfg       (cfg_q),
		.cur       (state_q),
		.cur_ticks (ticks_q),
		.nxt       (state_nxt),
		.nxt_ticks (ticks_nxt),
		.ev        (ev)
	);

	// Controller state, updated as each item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.enabled     <= 1'b0;
			state_q.stage       <= STG_IDLE;
			state_q.fault_count <= '0;
			state_q.drive       <= 1'b0;
			ticks_q             <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			ticks_q <= ticks_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {TICK_W'(ticks_nxt), ev, state_nxt.enabled,
			               state_nxt.stage, state_nxt.drive};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* rtl/trc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tank refill controller port checker
// Watches the top-level ports and flags inconsistent result transactions.
// ----------------------------------------------------------------------------
module trc_checker import trc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [M_TDATA_W-1:0]   m_tdata
);

	// A stalled result transaction stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The drive is on exactly while a filling stage is active.
	a_drive_stage: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == (m_tdata[2:1] != STG_IDLE))
		else $error("drive does not match stage");

	// A disabled controller is idle with the drive off.
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[2:0] == 3'd0)
		else $error("disabled controller not idle");

	// A fill start enters the first stage with a cleared counter.
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:4] == EV_START
		|-> m_tdata[2:1] == STG_EMPTY_TO_LOW && m_tdata[23:8] == 16'd0)
		else $error("fill start without cleared first stage");

endmodule

bind tank_refill_controller_unit trc_checker u_trc_checker (.*);
